// ----- design/bdm_pkg.sv -----
// Package for the 5x5 Bayer demosaic: sizes, types and kernel functions.
// Used by bdm_front, bdm_back and the top level; depends on nothing.
package bdm_pkg;
  localparam int MaxWidth = 1024;
  localparam int ColW = $clog2(MaxWidth);
  localparam int SizeW = 11;
  localparam int PixW = 16;
  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);
  localparam int QCntW = QPtrW + 1;
  localparam logic [1:0] RegImageSize = 2'd0;

  typedef logic [PixW-1:0] pix_t;
  typedef logic [ColW-1:0] pos_t;

  typedef struct packed {
    logic emit;
    logic odd_row;
    logic odd_col;
    logic eof;
    logic [1:0] row_phase;
    pix_t sample;
  } front_item_t;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
    logic end_of_frame;
  } rgb_t;

  function automatic pix_t diff3(logic [PixW-1:0] pos, logic [PixW-1:0] neg);
    logic [PixW:0] d;
    d = {1'b0, pos} - {1'b0, neg};
    return d[PixW] ? '0 : {3'b000, d[PixW-1:3]};
  endfunction
endpackage

// ----- design/bdm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module bdm_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ----- design/bdm_front.sv -----
// Front end: raster counters, frame position, interior classification and
// the short queue toward the back end. Depends on bdm_pkg.
module bdm_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [bdm_pkg::SizeW-1:0] image_size,
  input  logic                     size_wr,
  input  logic                     in_valid,
  input  bdm_pkg::pix_t            in_sample,
  output logic                     in_ready,
  output bdm_pkg::front_item_t     item,
  output bdm_pkg::pos_t            item_col,
  output logic                     item_valid,
  input  logic                     item_ready
);
  import bdm_pkg::*;

  logic [SizeW-1:0] eff;
  pos_t col, row, col_next, row_next, last;
  logic take;
  front_item_t cls;
  front_item_t fifo_item [QDepth];
  pos_t fifo_col [QDepth];
  logic [QPtrW-1:0] wptr, rptr;
  logic [QCntW-1:0] count;
  logic pop;

  always_comb begin
    if (image_size < SizeW'(5)) begin
      eff = SizeW'(5);
    end else if (image_size > SizeW'(MaxWidth)) begin
      eff = SizeW'(MaxWidth);
    end else begin
      eff = image_size;
    end
    last = ColW'(eff - SizeW'(1));
  end

  assign in_ready = (count != QCntW'(QDepth));
  assign take = in_valid && in_ready;
  assign item_valid = (count != '0);
  assign pop = item_valid && item_ready;
  assign item = fifo_item[rptr];
  assign item_col = fifo_col[rptr];

  always_comb begin
    col_next = col;
    row_next = row;
    if (take) begin
      if (col == last) begin
        col_next = '0;
        row_next = (row == last) ? '0 : row + ColW'(1);
      end else begin
        col_next = col + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || size_wr) begin
      col <= '0;
      row <= '0;
    end else begin
      col <= col_next;
      row <= row_next;
    end
  end

  always_comb begin
    cls.emit = (row >= ColW'(4)) && (col >= ColW'(4));
    cls.odd_row = row[0];
    cls.odd_col = col[0];
    cls.eof = (row == last) && (col == last);
    cls.row_phase = row[1:0];
    cls.sample = in_sample;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fifo_item[wptr] <= cls;
      fifo_col[wptr] <= col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (take) begin
        wptr <= wptr + QPtrW'(1);
      end
      if (pop) begin
        rptr <= rptr + QPtrW'(1);
      end
      case ({take, pop})
        2'b10: count <= count + QCntW'(1);
        2'b01: count <= count - QCntW'(1);
        default: count <= count;
      endcase
    end
  end
endmodule

// ----- design/bdm_back.sv -----
// Back end: line stores, 5x5 window, kernels and output register.
// Depends on bdm_pkg and bdm_ram.
module bdm_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  bdm_pkg::front_item_t q_item,
  input  bdm_pkg::pos_t        q_col,
  output logic                 q_ready,
  output bdm_pkg::rgb_t        rgb,
  output logic                 rgb_valid,
  input  logic                 rgb_ready
);
  import bdm_pkg::*;

  // Stage 1 registers the line-store read; stage 2 shifts the window;
  // stage 3 forms kernel sums; stage 4 holds the result.
  logic s1_v, s2_v, s3_v;
  front_item_t s1_it, s2_it;
  logic s3_eof, s3_orow, s3_ocol;
  pix_t win [5][5];
  logic [PixW-1:0] c3, ga_pos, ga_neg, h_pos, h_neg, v_pos, v_neg, o_pos, o_neg;
  logic adv;
  pix_t rd [4];

  assign adv = !rgb_valid || rgb_ready;
  assign q_ready = adv;

  for (genvar k = 0; k < 4; k++) begin : g_ln
    bdm_ram #(.Width(PixW), .Depth(MaxWidth)) u_ram (
      .clk(clk), .we(q_valid && adv && q_item.row_phase == 2'(k)),
      .waddr(q_col), .wdata(q_item.sample), .re(q_valid && adv),
      .raddr(q_col), .rdata(rd[k])
    );
  end

  // Window row i takes line store of phase (r+i)&3.
  pix_t col_in [4];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      col_in[i] = rd[2'(s1_it.row_phase + 2'(i))];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      rgb_valid <= 1'b0;
    end else if (adv) begin
      s1_v <= q_valid;
      s2_v <= s1_v;
      s3_v <= s2_v && s2_it.emit;
      rgb_valid <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_it <= q_item;
      s2_it <= s1_it;
      if (s1_v) begin
        for (int i = 0; i < 5; i++) begin
          for (int j = 0; j < 4; j++) begin
            win[i][j] <= win[i][j+1];
          end
        end
        for (int i = 0; i < 4; i++) begin
          win[i][4] <= col_in[i];
        end
        win[4][4] <= s1_it.sample;
      end
      s3_eof <= s2_it.eof;
      s3_orow <= s2_it.odd_row;
      s3_ocol <= s2_it.odd_col;
      c3 <= win[2][2];
      ga_pos <= PixW'({win[2][2], 2'b00}) + PixW'({win[1][2] + win[3][2] + win[2][1]
                + win[2][3], 1'b0});
      ga_neg <= win[0][2] + win[4][2] + win[2][0] + win[2][4];
      h_pos <= PixW'(({1'b0, win[0][2]} + {1'b0, win[4][2]}) >> 1)
               + PixW'({win[2][1], 2'b00}) + PixW'(win[2][2] * 3'd5)
               + PixW'({win[2][3], 2'b00});
      h_neg <= win[1][1] + win[1][3] + win[3][1] + win[3][3] + win[2][0] + win[2][4];
      v_pos <= PixW'(({1'b0, win[2][0]} + {1'b0, win[2][4]}) >> 1)
               + PixW'({win[1][2], 2'b00}) + PixW'(win[2][2] * 3'd5)
               + PixW'({win[3][2], 2'b00});
      v_neg <= win[0][2] + win[4][2] + win[1][1] + win[1][3] + win[3][1] + win[3][3];
      o_pos <= PixW'(win[2][2] * 3'd6) + PixW'({win[1][1] + win[1][3] + win[3][1]
               + win[3][3], 1'b0});
      o_neg <= PixW'(win[0][2] * 2'd3) + PixW'(win[2][0] * 2'd3)
               + PixW'(win[2][4] * 2'd3) + PixW'(win[4][2] * 2'd3);
    end
  end

  pix_t ga, hz, vt, op;
  logic [PixW+1:0] od;
  always_comb begin
    ga = diff3(ga_pos, ga_neg);
    hz = diff3(h_pos, h_neg);
    vt = diff3(v_pos, v_neg);
    od = {1'b0, o_pos, 1'b0} - {2'b00, o_neg};
    op = od[PixW+1] ? '0 : {3'b000, od[PixW:4]};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rgb.end_of_frame <= s3_eof;
      case ({s3_orow, s3_ocol})
        2'b00: begin
          rgb.red <= c3; rgb.green <= ga; rgb.blue <= op;
        end
        2'b01: begin
          rgb.green <= c3; rgb.red <= hz; rgb.blue <= vt;
        end
        2'b10: begin
          rgb.green <= c3; rgb.blue <= hz; rgb.red <= vt;
        end
        default: begin
          rgb.blue <= c3; rgb.green <= ga; rgb.red <= op;
        end
      endcase
    end
  end
endmodule

// ----- design/bayer_demosaic_5x5.sv -----
// Top level of the streaming 5x5 RGGB demosaic with APB size register.
// Depends on bdm_pkg, bdm_front, bdm_back.
//   channel  | handshake                     | payload
//   input    | raw_pixel_valid/ready         | raw_pixel
//   output   | rgb_valid/ready               | red, green, blue, end_of_frame
//   config   | psel/penable/pwrite/pready    | paddr, pwdata, prdata
// One pixel per cycle sustained while the output is being taken.
// The pipeline advances whenever the output register is empty or being taken.
// The input stalls only when the four-entry queue between front and back is full.
// Reset clears counters, valid flags and sets size 5; the line stores are not cleared.
module bayer_demosaic_5x5 (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        raw_pixel_valid,
  output logic        raw_pixel_ready,
  input  logic [15:0] raw_pixel,
  output logic        rgb_valid,
  input  logic        rgb_ready,
  output logic [15:0] red,
  output logic [15:0] green,
  output logic [15:0] blue,
  output logic        end_of_frame
);
  import bdm_pkg::*;

  logic [SizeW-1:0] image_size;
  logic wr;
  front_item_t item;
  pos_t icol;
  logic iv, ir;
  rgb_t rgb;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && paddr == RegImageSize;
  assign prdata = (paddr == RegImageSize) ? 32'(image_size) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= SizeW'(5);
    end else if (wr) begin
      image_size <= pwdata[SizeW-1:0];
    end
  end

  bdm_front u_front (
    .clk(clk), .rst(rst), .image_size(image_size), .size_wr(wr),
    .in_valid(raw_pixel_valid), .in_sample(raw_pixel), .in_ready(raw_pixel_ready),
    .item(item), .item_col(icol), .item_valid(iv), .item_ready(ir)
  );

  bdm_back u_back (
    .clk(clk), .rst(rst), .q_valid(iv), .q_item(item), .q_col(icol),
    .q_ready(ir), .rgb(rgb), .rgb_valid(rgb_valid), .rgb_ready(rgb_ready)
  );

  assign red = rgb.red;
  assign green = rgb.green;
  assign blue = rgb.blue;
  assign end_of_frame = rgb.end_of_frame;
endmodule

// ----- verif/tb_bayer_demosaic_5x5.sv -----
// Self-checking testbench for bayer_demosaic_5x5: raster frames of random and extreme
// samples, an in-house demosaic predictor, random stalls on both channels.
// Depends on bdm_pkg and the RTL of bayer_demosaic_5x5.
module tb_bayer_demosaic_5x5;
  timeunit 1ns;
  timeprecision 1ps;
  import bdm_pkg::*;

  localparam int StallLimit = 3000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic raw_pixel_valid = 1'b0;
  logic raw_pixel_ready;
  logic [15:0] raw_pixel = '0;
  logic rgb_valid;
  logic rgb_ready = 1'b0;
  logic [15:0] red, green, blue;
  logic end_of_frame;

  bayer_demosaic_5x5 dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state.
  logic [10:0] size_reg = 11'd5;
  pix_t rows_mem [0:4*MaxWidth-1];
  pix_t win [0:4][0:4];
  int unsigned col_pos = 0, row_pos = 0;
  rgb_t rgb_due [$];

  int errors = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;

  initial begin
    for (int k = 0; k < 4*MaxWidth; k++) rows_mem[k] = '0;
    for (int a = 0; a < 5; a++) for (int b = 0; b < 5; b++) win[a][b] = '0;
  end

  function automatic int unsigned px(int dy, int dx);
    return win[2+dy][2+dx];
  endfunction

  function automatic int unsigned sub_shift3(int unsigned pos, int unsigned neg);
    pos &= 32'hFFFF;
    neg &= 32'hFFFF;
    return (pos < neg) ? 0 : ((pos - neg) >> 3) & 32'hFFFF;
  endfunction

  function automatic int unsigned green_interp();
    return sub_shift3(4*px(0,0) + 2*(px(-1,0) + px(1,0) + px(0,-1) + px(0,1)),
                      px(-2,0) + px(2,0) + px(0,-2) + px(0,2));
  endfunction

  function automatic int unsigned horiz_interp();
    return sub_shift3(((px(-2,0) + px(2,0)) >> 1) + 4*px(0,-1) + 5*px(0,0) + 4*px(0,1),
                      px(-1,-1) + px(-1,1) + px(1,-1) + px(1,1) + px(0,-2) + px(0,2));
  endfunction

  function automatic int unsigned vert_interp();
    return sub_shift3(((px(0,-2) + px(0,2)) >> 1) + 4*px(-1,0) + 5*px(0,0) + 4*px(1,0),
                      px(-2,0) + px(2,0) + px(-1,-1) + px(-1,1) + px(1,-1) + px(1,1));
  endfunction

  function automatic int unsigned cross_interp();
    int unsigned pos, neg;
    pos = (6*px(0,0) + 2*(px(-1,-1) + px(-1,1) + px(1,-1) + px(1,1))) & 32'hFFFF;
    neg = (3*px(-2,0)) & 32'hFFFF;
    neg = (neg + 3*px(0,-2)) & 32'hFFFF;
    neg = (neg + 3*px(0,2)) & 32'hFFFF;
    neg = (neg + 3*px(2,0)) & 32'hFFFF;
    pos = pos << 1;
    return (pos < neg) ? 0 : ((pos - neg) >> 4) & 32'hFFFF;
  endfunction

  task automatic demosaic_predict(input pix_t sample);
    int unsigned n, r, c;
    rgb_t px_out;
    n = (size_reg < 5) ? 5 : (size_reg > MaxWidth) ? MaxWidth : size_reg;
    r = (row_pos >= n) ? n - 1 : row_pos;
    c = (col_pos >= n) ? n - 1 : col_pos;
    for (int a = 0; a < 5; a++) for (int b = 0; b < 4; b++) win[a][b] = win[a][b+1];
    for (int a = 0; a < 4; a++) win[a][4] = rows_mem[((r + a) & 3) * MaxWidth + c];
    win[4][4] = sample;
    rows_mem[(r & 3) * MaxWidth + c] = sample;
    if (r >= 4 && c >= 4) begin
      case ({r[0], c[0]})
        2'b00: begin
          px_out.red = pix_t'(px(0,0));
          px_out.green = pix_t'(green_interp());
          px_out.blue = pix_t'(cross_interp());
        end
        2'b01: begin
          px_out.green = pix_t'(px(0,0));
          px_out.red = pix_t'(horiz_interp());
          px_out.blue = pix_t'(vert_interp());
        end
        2'b10: begin
          px_out.green = pix_t'(px(0,0));
          px_out.blue = pix_t'(horiz_interp());
          px_out.red = pix_t'(vert_interp());
        end
        default: begin
          px_out.blue = pix_t'(px(0,0));
          px_out.green = pix_t'(green_interp());
          px_out.red = pix_t'(cross_interp());
        end
      endcase
      px_out.end_of_frame = (r == n - 1 && c == n - 1);
      rgb_due.push_back(px_out);
    end
    c++;
    if (c >= n) begin
      c = 0;
      r++;
      if (r >= n) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  task automatic send_pixel(input pix_t value);
    if (!calm && $urandom_range(0, 99) < 14) begin
      raw_pixel_valid <= 1'b0;
      @(posedge clk);
    end
    raw_pixel_valid <= 1'b1;
    raw_pixel <= value;
    do @(posedge clk); while (!raw_pixel_ready);
    demosaic_predict(value);
  endtask

  function automatic pix_t pick_sample();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 12) return '0;
    if (k < 24) return 16'hFFFF;
    return pix_t'($urandom);
  endfunction

  task automatic drain();
    raw_pixel_valid <= 1'b0;
    while (rgb_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_size(input int unsigned value);
    drain();
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= RegImageSize; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    size_reg = value[10:0];
    col_pos = 0;
    row_pos = 0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_frames(input int unsigned count, input int unsigned n);
    for (int unsigned k = 0; k < count * n * n; k++) send_pixel(pick_sample());
  endtask

  task automatic test_directed();
    write_size(5);
    for (int k = 0; k < 25; k++) send_pixel(16'hFFFF);
    for (int k = 0; k < 25; k++) send_pixel(((k / 5 + k % 5) % 2) ? 16'hFFFF : 16'h0000);
  endtask

  task automatic test_sizes();
    int unsigned n;
    write_size(0);
    send_frames(2, 5);
    write_size(3);
    send_frames(1, 5);
    for (int k = 0; k < 8; k++) begin
      n = $urandom_range(5, 10);
      write_size(n);
      calm = (k == 5);
      send_frames(1, n);
      if (k == 7) begin
        for (int j = 0; j < 40; j++) send_pixel(pick_sample());
        drain();
        for (int j = 0; j < 40; j++) send_pixel(pick_sample());
      end
    end
    calm = 1'b0;
    write_size(9);
    for (int j = 0; j < 50; j++) send_pixel(pick_sample());
  endtask

  task automatic test_largest();
    write_size(2047);
    for (int j = 0; j < 30; j++) send_pixel(pick_sample());
    write_size(12);
    send_frames(1, 12);
  endtask

  always @(posedge clk) begin
    if (!rst) rgb_ready <= calm || ($urandom_range(0, 99) >= 14);
  end

  always @(posedge clk) begin
    rgb_t want;
    if (!rst && rgb_valid && rgb_ready) begin
      if (rgb_due.size() == 0) begin
        $display("%0t: unexpected transaction, actual %h %h %h %b",
                 $time, red, green, blue, end_of_frame);
        errors++;
      end else begin
        want = rgb_due.pop_front();
        if (red !== want.red || green !== want.green || blue !== want.blue ||
            end_of_frame !== want.end_of_frame) begin
          $display("%0t: mismatch, expected %h %h %h %b, actual %h %h %h %b", $time,
                   want.red, want.green, want.blue, want.end_of_frame,
                   red, green, blue, end_of_frame);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((raw_pixel_valid && raw_pixel_ready) || (rgb_valid && rgb_ready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("tb_bayer_demosaic_5x5: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_sizes();
    test_largest();
    drain();
    if (errors == 0) begin
      $display("tb_bayer_demosaic_5x5: done, clean");
    end else begin
      $display("tb_bayer_demosaic_5x5: done, errors");
    end
    $finish;
  end
endmodule
